// ===== design/rsd_pkg.sv =====
`timescale 1ns / 1ps

package rsd_pkg;

  // Command codes of an input item
  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;

  // Frame geometry that does not vary
  localparam int unsigned SRC_LINES = 224;
  localparam int unsigned OUT_ROWS  = 128;

  // Reset value of the crop offset register
  localparam logic [5:0] CROP_RESET = 6'd16;

  // Division by 7: (v * RECIP7) >> RECIP7_SHIFT is exact for v < 1800
  localparam int unsigned RECIP7       = 2341;
  localparam int unsigned RECIP7_SHIFT = 14;

  // Per-channel halving mask for RGB565
  localparam logic [15:0] HALF_MASK = 16'hF7DE;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // Column and row fields of a back-end operation
  localparam int unsigned IDX_W = 8;
  localparam int unsigned ROW_W = 7;

  typedef struct packed {
    logic [1:0]  command;
    logic [8:0]  source_line;
    logic [7:0]  column;
    logic [15:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  out_row;
    logic [6:0]  out_col;
    logic [15:0] out_pixel;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_BLEND,
    OP_STORE,
    OP_FLUSH
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic              emit;
    logic [ROW_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [15:0]       pix;
  } bk_op_t;

  // Masked halving average of two RGB565 pixels
  function automatic logic [15:0] avg565(logic [15:0] a, logic [15:0] b);
    logic [15:0] half;
    half   = ((a ^ b) & HALF_MASK) >> 1;
    avg565 = half + (a & b);
  endfunction

endpackage

// ===== design/rsd_ram.sv =====
`timescale 1ns / 1ps

module rsd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same entry is written
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rsd_front.sv =====
`timescale 1ns / 1ps

module rsd_front import rsd_pkg::*; #(
  parameter int unsigned OUT_WIDTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  in_item_t   in_data_i,
  input  logic       queue_full_i,
  input  logic [5:0] crop_offset_i,
  output logic       push_valid_o,
  output bk_op_t     push_op_o
);

  localparam int unsigned NW  = $clog2(OUT_WIDTH + 1);
  localparam int unsigned SXW = NW + 4;

  logic              pend_valid_q, pend_valid_d;
  logic [ROW_W-1:0]  pend_row_q, pend_row_d;
  logic              blends_q, blends_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [15:0]       prev_pix_q, prev_pix_d;
  logic [NW-1:0]     next_col_q, next_col_d;

  logic              accept;
  logic [8:0]        line_m1;
  logic [22:0]       row_prod;
  logic [8:0]        row_full;
  logic              line_used;
  logic              line_start;
  logic [ROW_W-1:0]  row_eff;
  logic              blends_eff;
  logic [NW-1:0]     ox;
  logic [NW+2:0]     ox7;
  logic [SXW-1:0]    sx_plus1;
  logic              col_match;
  logic              ox_in_range;
  logic              ox_last;
  logic [15:0]       hpix;

  assign accept = in_valid_i && !queue_full_i;

  // Map source line to output row: (line-1)*4/7 by reciprocal multiply
  assign line_m1  = in_data_i.source_line - 9'd1;
  assign row_prod = 23'({line_m1, 2'b00}) * 23'(RECIP7);
  assign row_full = 9'(row_prod >> RECIP7_SHIFT);
  assign line_used = (in_data_i.source_line != 9'd0)
                  && (in_data_i.source_line <= 9'(SRC_LINES))
                  && (row_full < 9'(OUT_ROWS));

  // Line start overrides row, column counter and blend mode
  assign line_start = (in_data_i.column == 8'd0);
  assign row_eff    = line_start ? ROW_W'(row_full) : cur_row_q;
  assign blends_eff = line_start ? (pend_valid_q && (pend_row_q == ROW_W'(row_full)))
                                 : blends_q;
  assign ox         = line_start ? '0 : next_col_q;

  // Source column that completes output column ox
  assign ox7       = {ox, 3'b000} - (NW+3)'(ox);
  assign sx_plus1  = SXW'(ox7 >> 2) + SXW'(crop_offset_i) + SXW'(1);
  assign col_match = (SXW'(in_data_i.column) == sx_plus1);
  assign ox_in_range = (ox < NW'(OUT_WIDTH));
  assign ox_last     = (ox == NW'(OUT_WIDTH - 1));
  assign hpix        = avg565(prev_pix_q, in_data_i.pixel_in);

  // Classify the item and advance line state
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_row_d   = pend_row_q;
    blends_d     = blends_q;
    cur_row_d    = cur_row_q;
    prev_pix_d   = prev_pix_q;
    next_col_d   = next_col_q;
    push_valid_o = 1'b0;
    push_op_o    = '{kind: OP_FLUSH, emit: 1'b0, row: '0, col: '0, pix: '0};
    if (accept) begin
      unique case (in_data_i.command)
        CMD_FRAME: begin
          pend_valid_d = 1'b0;
          blends_d     = 1'b0;
          next_col_d   = '0;
        end
        CMD_FLUSH: begin
          if (pend_valid_q && ({1'b0, in_data_i.column} < 9'(OUT_WIDTH))) begin
            push_valid_o  = 1'b1;
            push_op_o.kind = OP_FLUSH;
            push_op_o.emit = 1'b1;
            push_op_o.row  = pend_row_q;
            push_op_o.col  = in_data_i.column;
            if ({1'b0, in_data_i.column} == 9'(OUT_WIDTH - 1)) begin
              pend_valid_d = 1'b0;
            end
          end
        end
        CMD_PIXEL: begin
          if (line_used) begin
            prev_pix_d = in_data_i.pixel_in;
            cur_row_d  = row_eff;
            blends_d   = blends_eff;
            next_col_d = ox;
            if (ox_in_range && col_match) begin
              push_valid_o   = 1'b1;
              push_op_o.kind = blends_eff ? OP_BLEND : OP_STORE;
              push_op_o.emit = blends_eff || pend_valid_q;
              push_op_o.row  = blends_eff ? row_eff : pend_row_q;
              push_op_o.col  = IDX_W'(ox);
              push_op_o.pix  = hpix;
              next_col_d     = ox + NW'(1);
              if (ox_last) begin
                if (blends_eff) begin
                  pend_valid_d = 1'b0;
                end else begin
                  pend_valid_d = 1'b1;
                  pend_row_d   = row_eff;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_row_q   <= '0;
      blends_q     <= 1'b0;
      cur_row_q    <= '0;
      prev_pix_q   <= '0;
      next_col_q   <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_row_q   <= pend_row_d;
      blends_q     <= blends_d;
      cur_row_q    <= cur_row_d;
      prev_pix_q   <= prev_pix_d;
      next_col_q   <= next_col_d;
    end
  end

endmodule

// ===== design/rsd_queue.sv =====
`timescale 1ns / 1ps

module rsd_queue import rsd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  bk_op_t push_op_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   valid_o,
  output bk_op_t head_o
);

  bk_op_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QUEUE_AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QUEUE_AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QUEUE_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed operation
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ===== design/rsd_back.sv =====
`timescale 1ns / 1ps

module rsd_back import rsd_pkg::*; #(
  parameter int unsigned OUT_WIDTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  input  bk_op_t    op_i,
  output logic      op_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(OUT_WIDTH);

  logic        b_valid_q, b_valid_d;
  bk_op_t      b_op_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q;
  logic        c_ready;
  logic        b_adv;
  logic [15:0] stored;
  logic [15:0] pix_res;

  assign c_ready  = !out_valid_q || !out_stall_i;
  assign b_adv    = !b_valid_q || c_ready;
  assign op_pop_o = op_valid_i && b_adv;

  // Row store: read the column, write the new first-line value on store ops
  rsd_ram #(
    .WIDTH(16),
    .DEPTH(OUT_WIDTH)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (op_pop_o && (op_i.kind == OP_STORE)),
    .waddr_i(AW'(op_i.col)),
    .wdata_i(op_i.pix),
    .re_i   (op_pop_o),
    .raddr_i(AW'(op_i.col)),
    .rdata_o(stored)
  );

  // Blend vertically or pass the stored value through
  assign pix_res = (b_op_q.kind == OP_BLEND) ? avg565(stored, b_op_q.pix) : stored;

  always_comb begin
    b_valid_d   = op_pop_o ? 1'b1 : (c_ready ? 1'b0 : b_valid_q);
    out_valid_d = c_ready ? (b_valid_q && b_op_q.emit) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payloads while stalled
  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      b_op_q <= op_i;
    end
    if (c_ready && b_valid_q) begin
      out_data_q.out_row   <= 7'(b_op_q.row);
      out_data_q.out_col   <= 7'(b_op_q.col);
      out_data_q.out_pixel <= pix_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/rgb565_scanline_downscaler_core.sv =====
`timescale 1ns / 1ps

// RGB565 scanline downscaler: takes one source item per clock and writes out
// 7:4 subsampled, 2x2 box-averaged framebuffer pixels. Sustained rate is one
// item per cycle, set by the single read port of the row store RAM that every
// producing item reads once. A result passes through the queue, the RAM read
// register and the output register; a four-entry queue between the
// line-tracking front end and the row store back end absorbs output stalls,
// and the input stalls only when that queue is full. The row store has no
// clearing pass and needs no start-up time. Write crop_offset only while idle.
module rgb565_scanline_downscaler_core import rsd_pkg::*; #(
  parameter int unsigned OUT_WIDTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i
);

  logic [5:0] crop_q;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       push_valid;
  bk_op_t     push_op;
  bk_op_t     head_op;

  // Crop offset register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crop_q <= CROP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      crop_q <= cfg_data_i;
    end
  end

  assign in_stall_o = q_full;

  rsd_front #(
    .OUT_WIDTH(OUT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .queue_full_i (q_full),
    .crop_offset_i(crop_q),
    .push_valid_o (push_valid),
    .push_op_o    (push_op)
  );

  rsd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_valid),
    .push_op_i(push_op),
    .pop_i    (q_pop),
    .full_o   (q_full),
    .valid_o  (q_valid),
    .head_o   (head_op)
  );

  rsd_back #(
    .OUT_WIDTH(OUT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (head_op),
    .op_pop_o   (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // A configuration write lands in the crop register on the next cycle
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> crop_q == $past(cfg_data_i))
    else $error("crop offset not updated by configuration write");

  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> !q_full)
    else $error("operation pushed into full queue");

  // The back end pops only real operations
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // An accepted item that produces an operation is queued in the same cycle
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> in_valid_i && !in_stall_o)
    else $error("operation pushed without an accepted item");

endmodule
